@@ hw/rtl/sha1_pkg.sv @@
`timescale 1ns / 1ps

package sha1_pkg;

   localparam logic [31:0] K_00_19 = 32'h5a827999;
   localparam logic [31:0] K_20_39 = 32'h6ed9eba1;
   localparam logic [31:0] K_40_59 = 32'h8f1bbcdc;
   localparam logic [31:0] K_60_79 = 32'hca62c1d6;

   // index 0 is h0
   localparam logic [4:0][31:0] H_INIT = {
      32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
   };

   localparam logic [7:0] PAD_BYTE    = 8'h80;
   localparam logic [6:0] ROUND_LAST  = 7'd79;
   localparam logic [5:0] LEN_START   = 6'd56;
   localparam logic [2:0] MAX_BYTES   = 3'd4;
   localparam logic [2:0] DIGEST_LAST = 3'd4;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_ABSORB = 8'b0000_0010,
      ST_PAD    = 8'b0000_0100,
      ST_LEN    = 8'b0000_1000,
      ST_LOAD   = 8'b0001_0000,
      ST_ROUND  = 8'b0010_0000,
      ST_UPDATE = 8'b0100_0000,
      ST_OUT    = 8'b1000_0000
   } sha1_state_type;

   typedef struct packed {
      logic accept;
      logic absorb;
      logic pad;
      logic len_blk;
      logic init;
      logic round;
      logic update;
      logic emit;
   } sha1_cmd_type;

   typedef struct packed {
      logic fill_block;
      logic hold_last;
      logic need_len;
      logic round_last;
      logic out_last;
   } sha1_stat_type;

   function automatic logic [31:0] sha1_f(input logic [6:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
      logic [31:0] res;
      if (rnd < 7'd20) begin
         res = (b & c) | (~b & d);
      end else if (rnd < 7'd40) begin
         res = b ^ c ^ d;
      end else if (rnd < 7'd60) begin
         res = (b & c) | (b & d) | (c & d);
      end else begin
         res = b ^ c ^ d;
      end
      return res;
   endfunction

   function automatic logic [31:0] sha1_k(input logic [6:0] rnd);
      logic [31:0] res;
      if (rnd < 7'd20) begin
         res = K_00_19;
      end else if (rnd < 7'd40) begin
         res = K_20_39;
      end else if (rnd < 7'd60) begin
         res = K_40_59;
      end else begin
         res = K_60_79;
      end
      return res;
   endfunction

endpackage

@@ hw/rtl/sha1_dp.sv @@
`timescale 1ns / 1ps

module sha1_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  sha1_pkg::sha1_cmd_type  cmd,
   output sha1_pkg::sha1_stat_type stat,
   input  logic [31:0]             in_word,
   input  logic [2:0]              in_count,
   input  logic                    in_last,
   output logic [31:0]             out_word,
   output logic [2:0]              out_index
);

   logic [15:0][31:0] buf_ff, buf_in;
   logic [4:0][31:0]  hash_ff, hash_in;
   logic [31:0]       a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]       a_in, b_in, c_in, d_in, e_in;
   logic [6:0]        rnd_ff, rnd_in;
   logic [5:0]        pend_ff, pend_in;
   logic [63:0]       total_ff, total_in;
   logic [31:0]       hold_word_ff, hold_word_in;
   logic [2:0]        hold_cnt_ff, hold_cnt_in;
   logic              hold_last_ff, hold_last_in;
   logic [2:0]        idx_ff, idx_in;

   logic [6:0]  room;
   logic [2:0]  fit;
   logic        fills;
   logic [63:0] bit_len;
   logic [31:0] sched_mix, sched_next, temp;
   logic [5:0]  off;

   // room left in the block, and how many held bytes go in now
   assign room    = 7'd64 - {1'b0, pend_ff};
   assign fills   = (hold_cnt_ff != 3'd0) && ({4'b0, hold_cnt_ff} >= room);
   assign fit     = fills ? room[2:0] : hold_cnt_ff;
   assign bit_len = {total_ff[60:0], 3'b000};

   assign sched_mix  = buf_ff[13] ^ buf_ff[8] ^ buf_ff[2] ^ buf_ff[0];
   assign sched_next = {sched_mix[30:0], sched_mix[31]};
   assign temp = {a_ff[26:0], a_ff[31:27]} + sha1_pkg::sha1_f(rnd_ff, b_ff, c_ff, d_ff)
               + e_ff + sha1_pkg::sha1_k(rnd_ff) + buf_ff[0];

   always_comb begin
      buf_in = buf_ff;
      off    = 6'd0;
      if (cmd.absorb) begin
         for (int q = 0; q < 64; q++) begin
            off = 6'(q) - pend_ff;
            if ((6'(q) >= pend_ff) && (off < {3'b000, fit})) begin
               buf_in[q / 4][(3 - (q % 4)) * 8 +: 8] =
                  hold_word_ff[(5'd24 - {off[1:0], 3'b000}) +: 8];
            end
         end
      end else if (cmd.pad) begin
         for (int q = 0; q < 64; q++) begin
            if (6'(q) == pend_ff) begin
               buf_in[q / 4][(3 - (q % 4)) * 8 +: 8] = sha1_pkg::PAD_BYTE;
            end else if (6'(q) > pend_ff) begin
               buf_in[q / 4][(3 - (q % 4)) * 8 +: 8] = 8'h00;
            end
         end
         if (pend_ff < sha1_pkg::LEN_START) begin
            buf_in[14] = bit_len[63:32];
            buf_in[15] = bit_len[31:0];
         end
      end else if (cmd.len_blk) begin
         buf_in     = '0;
         buf_in[14] = bit_len[63:32];
         buf_in[15] = bit_len[31:0];
      end else if (cmd.round) begin
         // rolling schedule window, buf_ff[0] is the current round's word
         for (int i = 0; i < 15; i++) begin
            buf_in[i] = buf_ff[i + 1];
         end
         buf_in[15] = sched_next;
      end
   end

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      e_in = e_ff;
      rnd_in = rnd_ff;
      if (cmd.init) begin
         a_in   = hash_ff[0];
         b_in   = hash_ff[1];
         c_in   = hash_ff[2];
         d_in   = hash_ff[3];
         e_in   = hash_ff[4];
         rnd_in = 7'd0;
      end else if (cmd.round) begin
         a_in   = temp;
         b_in   = a_ff;
         c_in   = {b_ff[1:0], b_ff[31:2]};
         d_in   = c_ff;
         e_in   = d_ff;
         rnd_in = rnd_ff + 7'd1;
      end
   end

   always_comb begin
      hash_in      = hash_ff;
      pend_in      = pend_ff;
      total_in     = total_ff;
      hold_word_in = hold_word_ff;
      hold_cnt_in  = hold_cnt_ff;
      hold_last_in = hold_last_ff;
      idx_in       = idx_ff;
      if (cmd.accept) begin
         hold_word_in = in_word;
         hold_cnt_in  = (in_count > sha1_pkg::MAX_BYTES) ? sha1_pkg::MAX_BYTES : in_count;
         hold_last_in = in_last;
      end
      if (cmd.absorb) begin
         hold_word_in = hold_word_ff << {fit, 3'b000};
         hold_cnt_in  = hold_cnt_ff - fit;
         pend_in      = pend_ff + {3'b000, fit};
         total_in     = total_ff + {61'd0, fit};
      end
      if (cmd.update) begin
         hash_in[0] = hash_ff[0] + a_ff;
         hash_in[1] = hash_ff[1] + b_ff;
         hash_in[2] = hash_ff[2] + c_ff;
         hash_in[3] = hash_ff[3] + d_ff;
         hash_in[4] = hash_ff[4] + e_ff;
      end
      if (cmd.emit) begin
         if (idx_ff == sha1_pkg::DIGEST_LAST) begin
            // digest delivered, start the next message
            idx_in       = 3'd0;
            hash_in      = sha1_pkg::H_INIT;
            pend_in      = 6'd0;
            total_in     = 64'd0;
            hold_last_in = 1'b0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff      <= sha1_pkg::H_INIT;
         rnd_ff       <= 7'd0;
         pend_ff      <= 6'd0;
         total_ff     <= 64'd0;
         hold_cnt_ff  <= 3'd0;
         hold_last_ff <= 1'b0;
         idx_ff       <= 3'd0;
      end else begin
         hash_ff      <= hash_in;
         rnd_ff       <= rnd_in;
         pend_ff      <= pend_in;
         total_ff     <= total_in;
         hold_cnt_ff  <= hold_cnt_in;
         hold_last_ff <= hold_last_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff       <= buf_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      c_ff         <= c_in;
      d_ff         <= d_in;
      e_ff         <= e_in;
      hold_word_ff <= hold_word_in;
   end

   assign stat.fill_block = fills;
   assign stat.hold_last  = hold_last_ff;
   assign stat.need_len   = pend_ff >= sha1_pkg::LEN_START;
   assign stat.round_last = rnd_ff == sha1_pkg::ROUND_LAST;
   assign stat.out_last   = idx_ff == sha1_pkg::DIGEST_LAST;

   assign out_word  = hash_ff[idx_ff];
   assign out_index = idx_ff;

endmodule

@@ hw/rtl/sha1_ctrl.sv @@
`timescale 1ns / 1ps

module sha1_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   output logic                    out_valid,
   input  logic                    out_ready,
   input  sha1_pkg::sha1_stat_type stat,
   output sha1_pkg::sha1_cmd_type  cmd
);

   sha1_pkg::sha1_state_type state_ff, state_in;
   sha1_pkg::sha1_state_type ret_ff, ret_in;

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      cmd      = '0;
      unique case (state_ff)
         sha1_pkg::ST_IDLE: begin
            if (in_valid) begin
               cmd.accept = 1'b1;
               state_in   = sha1_pkg::ST_ABSORB;
            end
         end
         sha1_pkg::ST_ABSORB: begin
            cmd.absorb = 1'b1;
            if (stat.fill_block) begin
               // leftover bytes go in after the block is hashed
               state_in = sha1_pkg::ST_LOAD;
               ret_in   = sha1_pkg::ST_ABSORB;
            end else if (stat.hold_last) begin
               state_in = sha1_pkg::ST_PAD;
            end else begin
               state_in = sha1_pkg::ST_IDLE;
            end
         end
         sha1_pkg::ST_PAD: begin
            cmd.pad  = 1'b1;
            state_in = sha1_pkg::ST_LOAD;
            ret_in   = stat.need_len ? sha1_pkg::ST_LEN : sha1_pkg::ST_OUT;
         end
         sha1_pkg::ST_LEN: begin
            cmd.len_blk = 1'b1;
            state_in    = sha1_pkg::ST_LOAD;
            ret_in      = sha1_pkg::ST_OUT;
         end
         sha1_pkg::ST_LOAD: begin
            cmd.init = 1'b1;
            state_in = sha1_pkg::ST_ROUND;
         end
         sha1_pkg::ST_ROUND: begin
            cmd.round = 1'b1;
            if (stat.round_last) begin
               state_in = sha1_pkg::ST_UPDATE;
            end
         end
         sha1_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ret_ff;
         end
         sha1_pkg::ST_OUT: begin
            if (out_ready) begin
               cmd.emit = 1'b1;
               if (stat.out_last) begin
                  state_in = sha1_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = sha1_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha1_pkg::ST_IDLE;
         ret_ff   <= sha1_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   assign in_ready  = state_ff == sha1_pkg::ST_IDLE;
   assign out_valid = state_ff == sha1_pkg::ST_OUT;

endmodule

@@ hw/rtl/sha1_hash_engine_core.sv @@
`timescale 1ns / 1ps

// channel   | ports        | tdata, low bit first                  | tlast
// ----------+--------------+---------------------------------------+----------
// request   | req_t*       | message_word[31:0], valid_bytes[34:32] | last_item
// response  | rsp_t*       | digest_word[31:0], word_index[34:32]   | last_word
//
// an item is taken while idle, then its bytes are packed into the block
// a full 64-byte block adds a load, 80 rounds, the chaining update and a repack
// a last item adds a pad step and a hashed block, plus a length step and a
// second block when the pad lands past byte 55, then five transfers
// reset is synchronous and restores the initial chaining value at once
// rsp_tready low holds the digest word; no request is taken until the digest is out

module sha1_hash_engine_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // message_word, valid_bytes, zero fill
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // digest_word, word_index, zero fill
   output logic        rsp_tlast
);

   sha1_pkg::sha1_cmd_type  cmd;
   sha1_pkg::sha1_stat_type stat;
   logic [31:0]             digest_word;
   logic [2:0]              word_index;

   sha1_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sha1_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .in_word   (req_tdata[31:0]),
      .in_count  (req_tdata[34:32]),
      .in_last   (req_tlast),
      .out_word  (digest_word),
      .out_index (word_index)
   );

   assign rsp_tdata = {5'd0, word_index, digest_word};
   assign rsp_tlast = stat.out_last;

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while digest pending");

   a_absorb_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready && !rsp_tvalid)
      else $error("accepted item not absorbed");

   a_digest_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> !rsp_tvalid && req_tready)
      else $error("digest did not end after last word");
`endif

endmodule

@@ tb/sv/sha1_hash_engine_core_test.sv @@
`timescale 1ns / 1ps

module sha1_hash_engine_core_test;

   localparam int IDLE_LIMIT = 2000;
   localparam int TAIL_CYCLES = 200;
   localparam int TARGET_ITEMS = 370;

   class sha1_digest_scoreboard;
      typedef struct packed {
         logic [31:0] word;
         logic [2:0]  index;
         logic        last;
      } digest_word_type;

      logic [31:0]     chain [5];
      logic [31:0]     block [16];
      logic [63:0]     byte_count;
      int unsigned     fill;
      digest_word_type digest_q [$];
      int unsigned     mismatches;
      int unsigned     words_checked;
      int unsigned     messages;

      function new();
         mismatches = 0;
         words_checked = 0;
         messages = 0;
         restart();
      endfunction

      function void restart();
         for (int i = 0; i < 5; i++) begin
            chain[i] = sha1_pkg::H_INIT[i];
         end
         for (int i = 0; i < 16; i++) begin
            block[i] = '0;
         end
         byte_count = '0;
         fill = 0;
      endfunction

      function void put_byte(input int unsigned pos, input logic [7:0] val);
         block[pos / 4][(3 - pos % 4) * 8 +: 8] = val;
      endfunction

      function void compress();
         logic [31:0] w [16];
         logic [31:0] a, b, c, d, e, f, k, x, t;
         w = block;
         a = chain[0];
         b = chain[1];
         c = chain[2];
         d = chain[3];
         e = chain[4];
         for (int r = 0; r < 80; r++) begin
            if (r < 16) begin
               x = w[r];
            end else begin
               x = w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16];
               x = {x[30:0], x[31]};
               w[r % 16] = x;
            end
            if (r < 20) begin
               f = (b & c) | (~b & d);
               k = sha1_pkg::K_00_19;
            end else if (r < 40) begin
               f = b ^ c ^ d;
               k = sha1_pkg::K_20_39;
            end else if (r < 60) begin
               f = (b & c) | (b & d) | (c & d);
               k = sha1_pkg::K_40_59;
            end else begin
               f = b ^ c ^ d;
               k = sha1_pkg::K_60_79;
            end
            t = {a[26:0], a[31:27]} + f + e + k + x;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
         end
         chain[0] += a;
         chain[1] += b;
         chain[2] += c;
         chain[3] += d;
         chain[4] += e;
      endfunction

      // absorbs one accepted request transfer, queues the digest on the last one
      function void note_request(input logic [31:0] word, input logic [2:0] code,
                                 input logic last);
         int unsigned n;
         logic [63:0] bit_len;
         n = (code > sha1_pkg::MAX_BYTES) ? sha1_pkg::MAX_BYTES : code;
         for (int i = 0; i < n; i++) begin
            put_byte(fill, word[31 - 8 * i -: 8]);
            fill = (fill + 1) % 64;
            byte_count++;
            if (fill == 0) begin
               compress();
            end
         end
         if (!last) begin
            return;
         end
         put_byte(fill, sha1_pkg::PAD_BYTE);
         fill++;
         // no room left for the length field: close this block first
         if (fill > sha1_pkg::LEN_START) begin
            while (fill < 64) begin
               put_byte(fill, 8'h00);
               fill++;
            end
            compress();
            fill = 0;
         end
         while (fill < sha1_pkg::LEN_START) begin
            put_byte(fill, 8'h00);
            fill++;
         end
         bit_len = byte_count << 3;
         block[14] = bit_len[63:32];
         block[15] = bit_len[31:0];
         compress();
         for (int i = 0; i < 5; i++) begin
            digest_q.push_back('{chain[i], 3'(i), (i == sha1_pkg::DIGEST_LAST)});
         end
         messages++;
         restart();
      endfunction

      function void note_mismatch(input string msg);
         if (mismatches < 10) begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
         end
         mismatches++;
      endfunction

      function void check_digest(input logic [39:0] data, input logic last);
         digest_word_type want;
         words_checked++;
         if (digest_q.size() == 0) begin
            note_mismatch($sformatf("unexpected digest word %h index %0d last %b",
                                    data[31:0], data[34:32], last));
            return;
         end
         want = digest_q.pop_front();
         if (data[31:0] !== want.word || data[34:32] !== want.index || last !== want.last) begin
            note_mismatch($sformatf("expected %h index %0d last %b, got %h index %0d last %b",
                                    want.word, want.index, want.last,
                                    data[31:0], data[34:32], last));
         end
      endfunction

      function int unsigned outstanding();
         return digest_q.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // message_word, valid_bytes, zero fill
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // digest_word, word_index, zero fill
   logic        rsp_tlast;

   sha1_digest_scoreboard sb = new();
   int unsigned items_sent = 0;
   int unsigned idle_cycles = 0;
   bit          req_calm = 1'b0;

   sha1_hash_engine_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_digest(rsp_tdata, rsp_tlast);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // response side: random stalls with calm stretches mixed in
   initial begin : digest_sink
      int unsigned stall;
      bit          calm;
      calm = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 19) == 0) begin
            calm = !calm;
         end
         stall = calm ? 0 : $urandom_range(0, 19);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   task automatic send_item(input logic [31:0] word, input logic [2:0] code,
                            input logic last);
      int unsigned gap;
      gap = req_calm ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= {5'b0, code, word};
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_request(word, code, last);
      items_sent++;
      @(negedge clock);
   endtask

   // holds the request side off until every digest word is back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (sb.outstanding() != 0);
   endtask

   // splits a message of the given byte length into random-sized transfers
   task automatic send_message(input int unsigned len);
      int unsigned left;
      int unsigned cnt;
      logic [2:0]  code;
      left = len;
      forever begin
         if (left <= 4 && $urandom_range(0, 1) == 1) begin
            code = (left == 4 && $urandom_range(0, 3) == 0) ?
                   3'($urandom_range(5, 7)) : 3'(left);
            send_item($urandom(), code, 1'b1);
            break;
         end
         cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 4;
         if (cnt > left) begin
            cnt = left;
         end
         // oversized byte counts still carry four bytes
         code = (cnt == 4 && $urandom_range(0, 7) == 0) ?
                3'($urandom_range(5, 7)) : 3'(cnt);
         send_item($urandom(), code, 1'b0);
         left -= cnt;
      end
   endtask

   initial begin : stimulus
      int unsigned len;
      bit          paused;
      paused = 1'b0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // empty message, with junk in the unused bytes
      send_item(32'hffffffff, 3'd0, 1'b1);
      // three-byte message, last byte ignored
      send_item(32'h616263ff, 3'd3, 1'b1);
      // oversized count on a last transfer
      send_item(32'hdeadbeef, 3'd7, 1'b1);
      send_item(32'hffffffff, 3'd5, 1'b0);
      send_item(32'h00000000, 3'd6, 1'b1);
      send_item(32'h12345678, 3'd1, 1'b0);
      send_item(32'h9abcdef0, 3'd2, 1'b1);
      // 55 bytes: pad and length just fit in one block
      send_item(32'hffffffff, 3'd4, 1'b0);
      send_item(32'h00000000, 3'd4, 1'b0);
      for (int i = 0; i < 11; i++) begin
         send_item($urandom(), 3'd4, 1'b0);
      end
      send_item($urandom(), 3'd3, 1'b1);
      drain();

      while (items_sent < TARGET_ITEMS) begin
         req_calm = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 3))
            0: len = $urandom_range(0, 20);
            1: len = 64 * $urandom_range(0, 2) + $urandom_range(52, 64);
            default: len = $urandom_range(0, 140);
         endcase
         send_message(len);
         if (!paused && items_sent >= TARGET_ITEMS / 2) begin
            drain();
            paused = 1'b1;
         end
      end
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d messages in %0d request transfers, %0d digest words checked",
               sb.messages, items_sent, sb.words_checked);
      $display("lengths spanned empty, pad-boundary and multi-block messages");
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
